// ----- hdl/jsu_pkg.sv -----
// Package with word types, codes and byte constants of the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

   // Input word: one raw byte of the string body or an end marker.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       input_end;
   } req_word_type;

   // Result word as delivered on the result channel.
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [2:0] error_code;
      logic       last;
   } rsp_word_type;

   // Result kinds.
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_NONE             = 3'd0;
   localparam logic [2:0] ERR_UNTERM_STRING    = 3'd1;
   localparam logic [2:0] ERR_UNTERM_ESCAPE    = 3'd2;
   localparam logic [2:0] ERR_TRUNC_UNICODE    = 3'd3;
   localparam logic [2:0] ERR_INVALID_UNICODE  = 3'd4;
   localparam logic [2:0] ERR_INVALID_ESCAPE   = 3'd5;

   // Characters of interest.
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CTRL_LF        = 8'h0A;
   localparam logic [7:0] CTRL_TAB       = 8'h09;
   localparam logic [7:0] CTRL_CR        = 8'h0D;
   localparam logic [7:0] CTRL_BS        = 8'h08;
   localparam logic [7:0] CTRL_FF        = 8'h0C;

   // UTF-8 lead and continuation marks.
   localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
   localparam logic [7:0]  UTF8_CONT   = 8'h80;
   localparam logic [15:0] UTF8_LIM1   = 16'h0080;
   localparam logic [15:0] UTF8_LIM2   = 16'h0800;

   // Decoder mode, one-hot.
   typedef enum logic [3:0] {
      MODE_TEXT = 4'b0001,
      MODE_ESC  = 4'b0010,
      MODE_HEX  = 4'b0100,
      MODE_DROP = 4'b1000
   } mode_type;

   // Command from the front to the back: one to three result words.
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] data;
      logic [1:0]      kind;
      logic [2:0]      error_code;
   } cmd_type;

   // Hex digit decode: bit 4 is set when the byte is a valid digit.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

endpackage

// ----- hdl/jsu_front.sv -----
// Front end: accepts input words, tracks escape state and builds result commands.
`timescale 1ns / 1ps

module jsu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  jsu_pkg::req_word_type req_word,
   output logic                  push,
   output jsu_pkg::cmd_type      push_cmd
);
   import jsu_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_accum_ff, code_accum_in;
   logic        bad_hex_ff, bad_hex_in;

   logic [4:0]  hex_dig;
   logic [15:0] code_next;
   logic [7:0]  b;

   assign b         = req_word.in_byte;
   assign hex_dig   = hex_decode(b);
   assign code_next = {code_accum_ff[11:0], (hex_dig[4] ? hex_dig[3:0] : 4'd0)};

   // Next state and command for the accepted word.
   always_comb begin
      mode_in       = mode_ff;
      hex_count_in  = hex_count_ff;
      code_accum_in = code_accum_ff;
      bad_hex_in    = bad_hex_ff;
      push          = 1'b0;
      push_cmd      = '0;
      push_cmd.count = 2'd1;
      if (req_fire) begin
         if (req_word.input_end) begin
            push_cmd.kind = KIND_ERR;
            unique case (mode_ff)
               MODE_TEXT: begin
                  push = 1'b1;
                  push_cmd.error_code = ERR_UNTERM_STRING;
               end
               MODE_ESC: begin
                  push = 1'b1;
                  push_cmd.error_code = ERR_UNTERM_ESCAPE;
               end
               MODE_HEX: begin
                  push = 1'b1;
                  push_cmd.error_code = ERR_TRUNC_UNICODE;
               end
               default: begin
                  push = 1'b0;
               end
            endcase
            mode_in       = MODE_TEXT;
            hex_count_in  = 2'd0;
            code_accum_in = 16'd0;
            bad_hex_in    = 1'b0;
         end else begin
            unique case (mode_ff)
               MODE_TEXT: begin
                  if (b == CHAR_QUOTE) begin
                     push = 1'b1;
                     push_cmd.kind = KIND_DONE;
                  end else if (b == CHAR_BACKSLASH) begin
                     mode_in = MODE_ESC;
                  end else begin
                     push = 1'b1;
                     push_cmd.kind = KIND_DATA;
                     push_cmd.data[0] = b;
                  end
               end
               MODE_ESC: begin
                  mode_in = MODE_TEXT;
                  push = 1'b1;
                  push_cmd.kind = KIND_DATA;
                  unique case (b)
                     CHAR_QUOTE:     push_cmd.data[0] = CHAR_QUOTE;
                     CHAR_BACKSLASH: push_cmd.data[0] = CHAR_BACKSLASH;
                     CHAR_SLASH:     push_cmd.data[0] = CHAR_SLASH;
                     CHAR_N:         push_cmd.data[0] = CTRL_LF;
                     CHAR_T:         push_cmd.data[0] = CTRL_TAB;
                     CHAR_R:         push_cmd.data[0] = CTRL_CR;
                     CHAR_B:         push_cmd.data[0] = CTRL_BS;
                     CHAR_F:         push_cmd.data[0] = CTRL_FF;
                     CHAR_U: begin
                        push          = 1'b0;
                        mode_in       = MODE_HEX;
                        hex_count_in  = 2'd0;
                        code_accum_in = 16'd0;
                        bad_hex_in    = 1'b0;
                     end
                     default: begin
                        mode_in = MODE_DROP;
                        push_cmd.kind = KIND_ERR;
                        push_cmd.error_code = ERR_INVALID_ESCAPE;
                     end
                  endcase
               end
               MODE_HEX: begin
                  if (hex_count_ff == 2'd3) begin
                     // Fourth digit position: report or encode.
                     push = 1'b1;
                     hex_count_in  = 2'd0;
                     code_accum_in = 16'd0;
                     bad_hex_in    = 1'b0;
                     if (bad_hex_ff || !hex_dig[4]) begin
                        mode_in = MODE_DROP;
                        push_cmd.kind = KIND_ERR;
                        push_cmd.error_code = ERR_INVALID_UNICODE;
                     end else begin
                        mode_in = MODE_TEXT;
                        push_cmd.kind = KIND_DATA;
                        if (code_next < UTF8_LIM1) begin
                           push_cmd.count = 2'd1;
                           push_cmd.data[0] = code_next[7:0];
                        end else if (code_next < UTF8_LIM2) begin
                           push_cmd.count = 2'd2;
                           push_cmd.data[0] = UTF8_LEAD2 | {3'd0, code_next[10:6]};
                           push_cmd.data[1] = UTF8_CONT | {2'd0, code_next[5:0]};
                        end else begin
                           push_cmd.count = 2'd3;
                           push_cmd.data[0] = UTF8_LEAD3 | {4'd0, code_next[15:12]};
                           push_cmd.data[1] = UTF8_CONT | {2'd0, code_next[11:6]};
                           push_cmd.data[2] = UTF8_CONT | {2'd0, code_next[5:0]};
                        end
                     end
                  end else begin
                     hex_count_in  = hex_count_ff + 2'd1;
                     code_accum_in = code_next;
                     bad_hex_in    = bad_hex_ff | ~hex_dig[4];
                  end
               end
               default: begin
                  // Dropping after an error.
                  push = 1'b0;
               end
            endcase
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_TEXT;
         hex_count_ff  <= 2'd0;
         code_accum_ff <= 16'd0;
         bad_hex_ff    <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         hex_count_ff  <= hex_count_in;
         code_accum_ff <= code_accum_in;
         bad_hex_ff    <= bad_hex_in;
      end
   end

endmodule

// ----- hdl/jsu_queue.sv -----
// Small command queue between the front end and the back end.
`timescale 1ns / 1ps

module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output jsu_pkg::cmd_type pop_cmd,
   output logic             empty
);
   import jsu_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   cmd_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/jsu_back.sv -----
// Back end: takes commands from the queue and sends their result words one per cycle while rsp_ready is high.
`timescale 1ns / 1ps

module jsu_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  jsu_pkg::cmd_type      q_cmd,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output jsu_pkg::rsp_word_type rsp_word
);
   import jsu_pkg::*;

   cmd_type    cur_ff, cur_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       is_last;

   assign is_last   = (idx_ff == cur_ff.count - 2'd1);
   assign rsp_valid = busy_ff;
   assign q_pop     = !q_empty && (!busy_ff || (rsp_ready && is_last));

   // Output word from the current command.
   always_comb begin
      rsp_word            = '0;
      rsp_word.kind       = cur_ff.kind;
      rsp_word.error_code = cur_ff.error_code;
      rsp_word.last       = is_last;
      unique case (idx_ff)
         2'd0:    rsp_word.out_byte = cur_ff.data[0];
         2'd1:    rsp_word.out_byte = cur_ff.data[1];
         2'd2:    rsp_word.out_byte = cur_ff.data[2];
         default: rsp_word.out_byte = 8'd0;
      endcase
   end

   // Command register and word index.
   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (q_pop) begin
         cur_in  = q_cmd;
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (busy_ff && rsp_ready) begin
         if (is_last) begin
            busy_in = 1'b0;
            idx_in  = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// ----- hdl/json_string_unescape.sv -----
// Top level of the JSON string unescaper.
//
// The req channel carries one word per byte of a JSON string body (after
// the opening quote), or an end marker with input_end set. The rsp channel
// carries result words: decoded data bytes, a done word on the closing
// quote, or an error word; last marks the final word caused by one input.
// Both channels use valid/ready and a word moves when both are high.
// The front end decodes an input word in the cycle it is accepted and
// writes a command of one to three result words into a queue of
// QUEUE_DEPTH entries. The back end registers the command and sends its
// words one per cycle while rsp_ready is high; a result is offered once
// its command has passed the queue entry and the command register. One
// input word is taken every cycle while the queue has room; a \u escape
// that expands to three UTF-8 bytes follows six inputs, so the stream
// runs at one word per cycle while the receiver is ready. When the
// receiver stalls, the back end holds its word and the queue fills;
// req_ready drops only when the queue is full.
// Reset clears the decoder to normal text, empties the queue and drops
// any word in flight.
`timescale 1ns / 1ps

module json_string_unescape #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  jsu_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output jsu_pkg::rsp_word_type rsp_word
);
   import jsu_pkg::*;

   logic    push, full, pop, empty;
   cmd_type push_cmd, pop_cmd;

   assign req_ready = !full;

   // Decoder front end.
   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_valid && req_ready),
      .req_word (req_word),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // Command queue.
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (empty)
   );

   // Result sender.
   jsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (empty),
      .q_cmd     (pop_cmd),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- tb/sv/unescape_checker.sv -----
// Checker for the JSON string unescaper: predicts result words and compares them.
`timescale 1ns / 1ps

module unescape_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  jsu_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  jsu_pkg::rsp_word_type rsp_word,
   output int                    mismatch_count,
   output int                    words_in_flight
);

   import jsu_pkg::*;

   // Decoder state of the prediction.
   mode_type    dec_mode;
   logic [2:0]  digits_seen;
   logic [15:0] code_point;
   logic        bad_digit;

   // Result words caused by the word being decoded, and all words still owed.
   rsp_word_type batch [3];
   int           batch_len;
   rsp_word_type decoded_words [$];
   rsp_word_type oldest;

   // One line per mismatch.
   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Value of a hex digit character, or -1 when the byte is not one.
   function automatic int digit_value(input logic [7:0] ch);
      if (ch inside {[8'h30:8'h39]}) return int'(ch) - 'h30;
      if (ch inside {[8'h61:8'h66]}) return int'(ch) - 'h61 + 10;
      if (ch inside {[8'h41:8'h46]}) return int'(ch) - 'h41 + 10;
      return -1;
   endfunction

   function automatic void emit(input logic [7:0] data, input logic [1:0] kind,
                                input logic [2:0] code);
      batch[batch_len] = '{out_byte: data, kind: kind, error_code: code, last: 1'b0};
      batch_len++;
   endfunction

   function automatic void clear_decoder();
      dec_mode    = MODE_TEXT;
      digits_seen = '0;
      code_point  = '0;
      bad_digit   = 1'b0;
   endfunction

   // Work out the result words that one accepted input word causes.
   task automatic unescape_word(input req_word_type w);
      int d;
      batch_len = 0;
      if (w.input_end) begin
         // The end marker closes whatever was open; dropping ends silently.
         case (dec_mode)
            MODE_TEXT: emit(8'h00, KIND_ERR, ERR_UNTERM_STRING);
            MODE_ESC:  emit(8'h00, KIND_ERR, ERR_UNTERM_ESCAPE);
            MODE_HEX:  emit(8'h00, KIND_ERR, ERR_TRUNC_UNICODE);
            default: ;
         endcase
         clear_decoder();
      end else begin
         case (dec_mode)
            MODE_TEXT: begin
               if (w.in_byte == CHAR_QUOTE) begin
                  emit(8'h00, KIND_DONE, ERR_NONE);
               end else if (w.in_byte == CHAR_BACKSLASH) begin
                  dec_mode = MODE_ESC;
               end else begin
                  emit(w.in_byte, KIND_DATA, ERR_NONE);
               end
            end
            MODE_ESC: begin
               dec_mode = MODE_TEXT;
               case (w.in_byte)
                  CHAR_QUOTE:     emit(CHAR_QUOTE, KIND_DATA, ERR_NONE);
                  CHAR_BACKSLASH: emit(CHAR_BACKSLASH, KIND_DATA, ERR_NONE);
                  CHAR_SLASH:     emit(CHAR_SLASH, KIND_DATA, ERR_NONE);
                  CHAR_N:         emit(CTRL_LF, KIND_DATA, ERR_NONE);
                  CHAR_T:         emit(CTRL_TAB, KIND_DATA, ERR_NONE);
                  CHAR_R:         emit(CTRL_CR, KIND_DATA, ERR_NONE);
                  CHAR_B:         emit(CTRL_BS, KIND_DATA, ERR_NONE);
                  CHAR_F:         emit(CTRL_FF, KIND_DATA, ERR_NONE);
                  CHAR_U: begin
                     dec_mode    = MODE_HEX;
                     digits_seen = '0;
                     code_point  = '0;
                     bad_digit   = 1'b0;
                  end
                  default: begin
                     dec_mode = MODE_DROP;
                     emit(8'h00, KIND_ERR, ERR_INVALID_ESCAPE);
                  end
               endcase
            end
            MODE_HEX: begin
               // A bad digit still takes a position; it is reported at the fourth.
               d = digit_value(w.in_byte);
               code_point = code_point << 4;
               if (d < 0) begin
                  bad_digit = 1'b1;
               end else begin
                  code_point[3:0] = d[3:0];
               end
               digits_seen++;
               if (digits_seen == 3'd4) begin
                  if (bad_digit) begin
                     emit(8'h00, KIND_ERR, ERR_INVALID_UNICODE);
                     dec_mode = MODE_DROP;
                  end else begin
                     if (code_point < UTF8_LIM1) begin
                        emit(code_point[7:0], KIND_DATA, ERR_NONE);
                     end else if (code_point < UTF8_LIM2) begin
                        emit(UTF8_LEAD2 | {3'b000, code_point[10:6]}, KIND_DATA, ERR_NONE);
                        emit(UTF8_CONT | {2'b00, code_point[5:0]}, KIND_DATA, ERR_NONE);
                     end else begin
                        emit(UTF8_LEAD3 | {4'h0, code_point[15:12]}, KIND_DATA, ERR_NONE);
                        emit(UTF8_CONT | {2'b00, code_point[11:6]}, KIND_DATA, ERR_NONE);
                        emit(UTF8_CONT | {2'b00, code_point[5:0]}, KIND_DATA, ERR_NONE);
                     end
                     dec_mode = MODE_TEXT;
                  end
                  digits_seen = '0;
                  code_point  = '0;
                  bad_digit   = 1'b0;
               end
            end
            default: ;
         endcase
      end
      if (batch_len > 0) begin
         batch[batch_len - 1].last = 1'b1;
      end
      for (int i = 0; i < batch_len; i++) begin
         decoded_words.insert(decoded_words.size(), batch[i]);
      end
   endtask

   // Predict on every accepted input word and check every accepted result word.
   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         decoded_words.delete();
      end else begin
         if (req_valid && req_ready) begin
            unescape_word(req_word);
         end
         if (rsp_valid && rsp_ready) begin
            if (decoded_words.size() == 0) begin
               report_mismatch($sformatf("result word %p with nothing expected", rsp_word));
            end else begin
               oldest = decoded_words.pop_front();
               if (rsp_word.out_byte !== oldest.out_byte) begin
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp_word.out_byte, oldest.out_byte));
               end
               if (rsp_word.kind !== oldest.kind) begin
                  report_mismatch($sformatf("kind %0d, expected %0d",
                                            rsp_word.kind, oldest.kind));
               end
               if (rsp_word.error_code !== oldest.error_code) begin
                  report_mismatch($sformatf("error_code %0d, expected %0d",
                                            rsp_word.error_code, oldest.error_code));
               end
               if (rsp_word.last !== oldest.last) begin
                  report_mismatch($sformatf("last %b, expected %b",
                                            rsp_word.last, oldest.last));
               end
            end
         end
      end
      words_in_flight <= decoded_words.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the JSON string unescaper testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

   import jsu_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 350;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   int mismatch_count;
   int words_in_flight;
   int cycle_count  = 0;
   int burst_left   = 0;
   bit valid_held   = 1'b0;
   int useful_items = 0;
   bit drained_mid  = 1'b0;

   // Receiver behavior: a style that is redrawn when its random run ends.
   int ready_style = 0;
   int style_left  = 0;

   // The eight single-character escape letters.
   logic [7:0] escape_letters [8] = '{CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH, CHAR_N,
                                      CHAR_T, CHAR_R, CHAR_B, CHAR_F};

   json_string_unescape dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   unescape_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word        (rsp_word),
      .mismatch_count  (mismatch_count),
      .words_in_flight (words_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a run that does not finish in time fails.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // Result side: always ready, random, mostly ready or mostly stalled.
   always @(posedge clock) begin
      if (style_left == 0) begin
         ready_style <= $urandom_range(0, 3);
         style_left  <= $urandom_range(16, 96);
      end else begin
         style_left <= style_left - 1;
      end
      case (ready_style)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= ($urandom_range(0, 7) != 0);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Offer one word and hold it until accepted; bursts end in a random gap, or in none.
   task automatic send_word(input logic [7:0] data, input logic at_end, input bit counted);
      int gap;
      req_word   <= '{in_byte: data, input_end: at_end};
      req_valid  <= 1'b1;
      valid_held  = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (counted) useful_items++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid  <= 1'b0;
            valid_held  = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid if it is still held after the last accepted word.
   task automatic hold_off();
      if (valid_held) begin
         req_valid  <= 1'b0;
         valid_held  = 1'b0;
      end
   endtask

   task automatic wait_for_drain();
      hold_off();
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
   endtask

   // Send hex digit characters of a code point, most significant first, in
   // random letter case; the digit at bad_pos becomes a non-hex byte.
   task automatic send_hex_digits(input logic [15:0] cp, input int bad_pos, input int digits);
      logic [3:0] nib;
      logic [7:0] ch;
      for (int i = 0; i < digits; i++) begin
         nib = cp[15 - 4 * i -: 4];
         if (i == bad_pos) begin
            ch = 8'($urandom_range(0, 255));
            if (ch inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]}) ch = 8'h7A;
         end else if (nib < 4'd10) begin
            ch = 8'h30 + nib;
         end else begin
            ch = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
         end
         send_word(ch, 1'b0, 1'b1);
      end
   endtask

   // Random bytes that fall while dropping, then the end marker.
   task automatic send_junk_and_end();
      repeat ($urandom_range(0, 3)) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
   endtask

   initial begin
      int         pick;
      logic [7:0] ch;
      logic [15:0] cp;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: byte extremes, done, \u0000, a surrogate, every error kind.
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'hFF, 1'b0, 1'b1);
      send_word(CHAR_QUOTE, 1'b0, 1'b1);
      send_word(CHAR_BACKSLASH, 1'b0, 1'b1);
      send_word(CHAR_U, 1'b0, 1'b1);
      send_hex_digits(16'h0000, -1, 4);
      send_word(CHAR_BACKSLASH, 1'b0, 1'b1);
      send_word(CHAR_U, 1'b0, 1'b1);
      send_hex_digits(16'hDBFF, -1, 4);
      send_word(8'hA5, 1'b1, 1'b1);
      send_word(CHAR_BACKSLASH, 1'b0, 1'b1);
      send_word(8'h5A, 1'b1, 1'b1);
      // Truncation wins over an invalid digit that already arrived.
      send_word(CHAR_BACKSLASH, 1'b0, 1'b1);
      send_word(CHAR_U, 1'b0, 1'b1);
      send_hex_digits(16'h0000, 0, 1);
      send_word(8'h00, 1'b1, 1'b1);
      // Unknown escape letter, then the end marker while dropping.
      send_word(CHAR_BACKSLASH, 1'b0, 1'b1);
      send_word(8'h71, 1'b0, 1'b1);
      send_word(8'hFF, 1'b1, 1'b0);
      // Invalid digit in the last position.
      send_word(CHAR_BACKSLASH, 1'b0, 1'b1);
      send_word(CHAR_U, 1'b0, 1'b1);
      send_hex_digits(16'h1230, 3, 4);
      send_word(8'h00, 1'b1, 1'b0);
      wait_for_drain();

      // Random: mostly well-formed text and escapes, some errors and ends.
      useful_items = 0;
      while (useful_items < RANDOM_ITEMS) begin
         if (!drained_mid && useful_items >= RANDOM_ITEMS / 2) begin
            drained_mid = 1'b1;
            wait_for_drain();
         end
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            ch = 8'($urandom_range(0, 255));
            if (ch == CHAR_QUOTE || ch == CHAR_BACKSLASH) ch = ch ^ 8'h01;
            send_word(ch, 1'b0, 1'b1);
         end else if (pick < 55) begin
            send_word(CHAR_BACKSLASH, 1'b0, 1'b1);
            send_word(escape_letters[$urandom_range(0, 7)], 1'b0, 1'b1);
         end else if (pick < 75) begin
            case ($urandom_range(0, 2))
               0:       cp = 16'($urandom_range(0, 16'h007F));
               1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
               default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            send_word(CHAR_BACKSLASH, 1'b0, 1'b1);
            send_word(CHAR_U, 1'b0, 1'b1);
            send_hex_digits(cp, -1, 4);
         end else if (pick < 83) begin
            send_word(CHAR_QUOTE, 1'b0, 1'b1);
         end else if (pick < 86) begin
            send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
         end else if (pick < 90) begin
            ch = 8'($urandom_range(0, 255));
            if (ch inside {CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH, CHAR_N, CHAR_T,
                           CHAR_R, CHAR_B, CHAR_F, CHAR_U}) ch = 8'h71;
            send_word(CHAR_BACKSLASH, 1'b0, 1'b1);
            send_word(ch, 1'b0, 1'b1);
            send_junk_and_end();
         end else if (pick < 94) begin
            send_word(CHAR_BACKSLASH, 1'b0, 1'b1);
            send_word(CHAR_U, 1'b0, 1'b1);
            send_hex_digits(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3), 4);
            send_junk_and_end();
         end else if (pick < 97) begin
            send_word(CHAR_BACKSLASH, 1'b0, 1'b1);
            send_word(CHAR_U, 1'b0, 1'b1);
            send_hex_digits(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 4) - 1,
                            $urandom_range(0, 3));
            send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
         end else begin
            send_word(CHAR_BACKSLASH, 1'b0, 1'b1);
            send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
         end
      end

      // Let every owed word arrive, then wait for strays before the verdict.
      wait_for_drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
